>>> src/ray_circle_intersection_macros.svh
`ifndef RAY_CIRCLE_INTERSECTION_MACROS_SVH
`define RAY_CIRCLE_INTERSECTION_MACROS_SVH

// property that must hold at every sampled edge
`define RCI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition in one cycle implies consequence in the next
`define RCI_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) else $error(msg);

`endif

>>> src/rci_pkg.sv
package rci_pkg;

  localparam int CoordW  = 32;
  localparam int DirW    = 19;
  localparam int RadW    = 31;
  localparam int DiffW   = 33;
  localparam int ProdW   = 52;
  localparam int SqW     = 65;
  localparam int Dist2W  = 66;
  localparam int UuW     = 37;
  localparam int AnW     = 38;
  localparam int R2W     = 62;
  localparam int PnW     = 53;
  localparam int MagW    = 52;
  localparam int ArW     = AnW + R2W;
  localparam int NumW    = 2 * MagW;
  localparam int QuoW    = 64;
  localparam int RootW   = QuoW / 2;
  localparam int LenW    = 32;
  localparam int CfgIdxW = 2;
  localparam int DivLat  = QuoW + 1;
  localparam int SqrtLat = RootW;

  localparam logic [RadW-1:0] RADIUS_RESET = 31'd65536;
  localparam logic [R2W-1:0]  RR2_RESET    = 62'h1_0000_0000;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_CENTER_X = 2'd0,
    CFG_CENTER_Y = 2'd1,
    CFG_RADIUS   = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic valid;
    logic in_circ;
    logic hit_ok;
    logic pn_neg;
  } side_t;

endpackage

>>> src/ray_circle_intersection.sv
// channel | direction | handshake             | word
// in      | input     | in_valid_i/in_ready_o   | origin_x, origin_y, dir_x, dir_y
// out     | output    | out_valid_o/out_ready_i | hit, inside_error, hit_length
// cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_index, cfg_data
//
// one word accepted per cycle while the output is not stalled
// most of the pipeline depth lies in the 65 stage divider and the 32 stage square root
// reset clears valid bits and loads center 0, radius 1.0
// a stalled output freezes the whole pipeline, in_ready_o follows it
module ray_circle_intersection (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [rci_pkg::CoordW-1:0]   origin_x_i,
  input  logic signed [rci_pkg::CoordW-1:0]   origin_y_i,
  input  logic signed [rci_pkg::DirW-1:0]     dir_x_i,
  input  logic signed [rci_pkg::DirW-1:0]     dir_y_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                hit_o,
  output logic                                inside_error_o,
  output logic [rci_pkg::LenW-1:0]            hit_length_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [rci_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  logic [rci_pkg::CoordW-1:0]          cfg_data_i
);

  `include "ray_circle_intersection_macros.svh"

  logic en;

  logic signed [rci_pkg::CoordW-1:0] center_x_q, center_y_q;
  logic [rci_pkg::RadW-1:0]          radius_q;
  logic [rci_pkg::R2W-1:0]           rr2_d, rr2_q;

  logic                              s1_valid_q, s2_valid_q, s3_valid_q;
  logic signed [rci_pkg::DiffW-1:0]  a_d, b_d, a_q, b_q;
  logic signed [rci_pkg::DirW-1:0]   u_q, v_q;

  logic signed [2*rci_pkg::DiffW-1:0] aa_full, bb_full;
  logic signed [2*rci_pkg::DirW-1:0]  uu_full, vv_full;
  logic signed [rci_pkg::ProdW-1:0]   au_d, bv_d, av_d, bu_d;
  logic signed [rci_pkg::ProdW-1:0]   au_q, bv_q, av_q, bu_q;
  logic [rci_pkg::SqW-1:0]            aa_q, bb_q;
  logic [rci_pkg::UuW-1:0]            uu_q, vv_q;

  logic signed [rci_pkg::PnW-1:0]     pn_d, xn_d;
  logic [rci_pkg::MagW-1:0]           pnm_d, xnm_d, pnm_q, xnm_q;
  logic [rci_pkg::Dist2W-1:0]         dist2_d, dist2_q;
  logic [rci_pkg::AnW-1:0]            an_d, an_q;
  logic                               pn_neg_q;

  rci_pkg::side_t                     s4_side_q, s5_side_q, s6_side_d, s6_side_q;
  logic [rci_pkg::AnW-1:0]            s4_an_q, s5_an_q, s6_an_q;

  logic [rci_pkg::ArW-1:0]            ar;
  logic [rci_pkg::NumW-1:0]           c2, pp;
  logic [rci_pkg::ArW-1:0]            dn_d, dn_q;
  logic [rci_pkg::NumW-1:0]           pp_q;

  logic [rci_pkg::QuoW-1:0]           w_quo, p_quo;
  logic [rci_pkg::RootW-1:0]          w_root, p_root;
  rci_pkg::side_t                     fin_side;

  logic [rci_pkg::LenW:0]             diff, sum, sel;
  logic [rci_pkg::LenW-1:0]           len_d;

  logic                               out_valid_q, hit_q, inside_q;
  logic [rci_pkg::LenW-1:0]           len_q;

  assign en          = !out_valid_q || out_ready_i;
  assign in_ready_o  = en;
  assign cfg_ready_o = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q <= '0;
      center_y_q <= '0;
      radius_q   <= rci_pkg::RADIUS_RESET;
      rr2_q      <= rci_pkg::RR2_RESET;
    end else begin
      rr2_q <= rr2_d;
      if (cfg_valid_i) begin
        unique case (rci_pkg::cfg_reg_e'(cfg_index_i))
          rci_pkg::CFG_CENTER_X: center_x_q <= cfg_data_i;
          rci_pkg::CFG_CENTER_Y: center_y_q <= cfg_data_i;
          rci_pkg::CFG_RADIUS:   radius_q   <= cfg_data_i[rci_pkg::RadW-1:0];
          default: ;
        endcase
      end
    end
  end

  assign rr2_d = radius_q * radius_q;

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q <= in_valid_i;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
    end
  end

  // stage 1: offset from center
  assign a_d = origin_x_i - center_x_q;
  assign b_d = origin_y_i - center_y_q;

  // stage 2: products
  assign aa_full = a_q * a_q;
  assign bb_full = b_q * b_q;
  assign uu_full = u_q * u_q;
  assign vv_full = v_q * v_q;
  assign au_d    = a_q * u_q;
  assign bv_d    = b_q * v_q;
  assign av_d    = a_q * v_q;
  assign bu_d    = b_q * u_q;

  // stage 3: sums and magnitudes
  assign pn_d    = au_q + bv_q;
  assign xn_d    = av_q - bu_q;
  assign pnm_d   = pn_d[rci_pkg::PnW-1] ? rci_pkg::MagW'(-pn_d) : pn_d[rci_pkg::MagW-1:0];
  assign xnm_d   = xn_d[rci_pkg::PnW-1] ? rci_pkg::MagW'(-xn_d) : xn_d[rci_pkg::MagW-1:0];
  assign dist2_d = rci_pkg::Dist2W'(aa_q) + rci_pkg::Dist2W'(bb_q);
  assign an_d    = rci_pkg::AnW'(uu_q) + rci_pkg::AnW'(vv_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_q      <= a_d;
      b_q      <= b_d;
      u_q      <= dir_x_i;
      v_q      <= dir_y_i;
      aa_q     <= aa_full[rci_pkg::SqW-1:0];
      bb_q     <= bb_full[rci_pkg::SqW-1:0];
      uu_q     <= uu_full[rci_pkg::UuW-1:0];
      vv_q     <= vv_full[rci_pkg::UuW-1:0];
      au_q     <= au_d;
      bv_q     <= bv_d;
      av_q     <= av_d;
      bu_q     <= bu_d;
      pnm_q    <= pnm_d;
      xnm_q    <= xnm_d;
      pn_neg_q <= pn_d[rci_pkg::PnW-1];
      dist2_q  <= dist2_d;
      an_q     <= an_d;
      s4_an_q  <= an_q;
      s5_an_q  <= s4_an_q;
      s6_an_q  <= s5_an_q;
      dn_q     <= dn_d;
      pp_q     <= pp;
    end
  end

  // stages 4 and 5: wide squares and scaled radius
  rci_mul #(.WA(rci_pkg::AnW), .WB(rci_pkg::R2W)) u_mul_ar (
    .clk_i (clk_i),
    .en_i  (en),
    .a_i   (an_q),
    .b_i   (rr2_q),
    .p_o   (ar)
  );

  rci_mul #(.WA(rci_pkg::MagW), .WB(rci_pkg::MagW)) u_mul_xn (
    .clk_i (clk_i),
    .en_i  (en),
    .a_i   (xnm_q),
    .b_i   (xnm_q),
    .p_o   (c2)
  );

  rci_mul #(.WA(rci_pkg::MagW), .WB(rci_pkg::MagW)) u_mul_pn (
    .clk_i (clk_i),
    .en_i  (en),
    .a_i   (pnm_q),
    .b_i   (pnm_q),
    .p_o   (pp)
  );

  // stage 6: discriminant
  always_comb begin
    s6_side_d        = s5_side_q;
    s6_side_d.hit_ok = !s5_side_q.in_circ && (rci_pkg::NumW'(ar) > c2);
  end
  assign dn_d = ar - c2[rci_pkg::ArW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_side_q <= '0;
      s5_side_q <= '0;
      s6_side_q <= '0;
    end else if (en) begin
      s4_side_q.valid   <= s3_valid_q;
      s4_side_q.in_circ <= dist2_q <= rci_pkg::Dist2W'(rr2_q);
      s4_side_q.hit_ok  <= 1'b0;
      s4_side_q.pn_neg  <= pn_neg_q;
      s5_side_q         <= s4_side_q;
      s6_side_q         <= s6_side_d;
    end
  end

  // half chord and foot distance
  rci_div #(.NW(rci_pkg::NumW), .DW(rci_pkg::AnW), .QW(rci_pkg::QuoW)) u_div_w (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (rci_pkg::NumW'(dn_q)),
    .den_i (s6_an_q),
    .quo_o (w_quo)
  );

  rci_div #(.NW(rci_pkg::NumW), .DW(rci_pkg::AnW), .QW(rci_pkg::QuoW)) u_div_p (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (pp_q),
    .den_i (s6_an_q),
    .quo_o (p_quo)
  );

  rci_sqrt #(.N(rci_pkg::RootW)) u_sqrt_w (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (w_quo),
    .root_o (w_root)
  );

  rci_sqrt #(.N(rci_pkg::RootW)) u_sqrt_p (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (p_quo),
    .root_o (p_root)
  );

  rci_delay #(.DEPTH(rci_pkg::DivLat + rci_pkg::SqrtLat)) u_delay (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .side_i (s6_side_q),
    .side_o (fin_side)
  );

  // nearer crossing, saturated
  assign diff  = {1'b0, p_root} - {1'b0, w_root};
  assign sum   = {1'b0, p_root} + {1'b0, w_root};
  assign sel   = fin_side.pn_neg ? diff : sum;
  assign len_d = sel[rci_pkg::LenW] ? '1 : sel[rci_pkg::LenW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= fin_side.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      hit_q    <= fin_side.hit_ok;
      inside_q <= fin_side.in_circ;
      len_q    <= fin_side.hit_ok ? len_d : '0;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign hit_o          = hit_q;
  assign inside_error_o = inside_q;
  assign hit_length_o   = len_q;

  `RCI_ASSERT(a_hit_excl, out_valid_o |-> !(hit_o && inside_error_o), "hit with inside error")
  `RCI_ASSERT(a_len_miss, (out_valid_o && !hit_o) |-> (hit_length_o == '0), "length on miss")
  `RCI_ASSERT_NEXT(a_freeze, !in_ready_o, $stable(s6_side_q), "pipeline moved in stall")

endmodule

>>> src/rci_mul.sv
module rci_mul #(
  parameter int WA = 38,
  parameter int WB = 62
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [WA-1:0]    a_i,
  input  logic [WB-1:0]    b_i,
  output logic [WA+WB-1:0] p_o
);

  localparam int HA = WA - 32;
  localparam int HB = WB - 32;
  localparam int PW = WA + WB;

  logic [63:0]      p00_d, p00_q;
  logic [HB+31:0]   p01_d, p01_q;
  logic [HA+31:0]   p10_d, p10_q;
  logic [HA+HB-1:0] p11_d, p11_q;
  logic [PW-1:0]    p_d, p_q;

  // split into partial products of at most 32 by 32 bits
  assign p00_d = a_i[31:0] * b_i[31:0];
  assign p01_d = a_i[31:0] * b_i[WB-1:32];
  assign p10_d = a_i[WA-1:32] * b_i[31:0];
  assign p11_d = a_i[WA-1:32] * b_i[WB-1:32];

  assign p_d = PW'(p00_q) + (PW'(p01_q) << 32) + (PW'(p10_q) << 32) + (PW'(p11_q) << 64);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p00_q <= p00_d;
      p01_q <= p01_d;
      p10_q <= p10_d;
      p11_q <= p11_d;
      p_q   <= p_d;
    end
  end

  assign p_o = p_q;

endmodule

>>> src/rci_div.sv
module rci_div #(
  parameter int NW = 104,
  parameter int DW = 38,
  parameter int QW = 64
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic [QW-1:0] quo_o
);

  localparam int HW = NW - QW;

  logic [DW-1:0] rem_d [QW+1];
  logic [DW-1:0] rem_q [QW+1];
  logic [QW-1:0] nq_d  [QW+1];
  logic [QW-1:0] nq_q  [QW+1];
  logic [DW-1:0] den_d [QW+1];
  logic [DW-1:0] den_q [QW+1];
  logic          sat_d [QW+1];
  logic          sat_q [QW+1];
  logic [DW:0]   part  [QW];
  logic          ge    [QW];

  // restoring division, one quotient bit per stage
  always_comb begin
    rem_d[0] = num_i[QW+DW-1:QW];
    nq_d[0]  = num_i[QW-1:0];
    den_d[0] = den_i;
    sat_d[0] = num_i[NW-1:QW] >= HW'(den_i);
    for (int k = 0; k < QW; k++) begin
      part[k]    = {rem_q[k], nq_q[k][QW-1]};
      ge[k]      = part[k] >= {1'b0, den_q[k]};
      rem_d[k+1] = ge[k] ? DW'(part[k] - {1'b0, den_q[k]}) : part[k][DW-1:0];
      nq_d[k+1]  = {nq_q[k][QW-2:0], ge[k]};
      den_d[k+1] = den_q[k];
      sat_d[k+1] = sat_q[k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q <= rem_d;
      nq_q  <= nq_d;
      den_q <= den_d;
      sat_q <= sat_d;
    end
  end

  assign quo_o = sat_q[QW] ? '1 : nq_q[QW];

endmodule

>>> src/rci_sqrt.sv
module rci_sqrt #(
  parameter int N = 32
) (
  input  logic           clk_i,
  input  logic           en_i,
  input  logic [2*N-1:0] rad_i,
  output logic [N-1:0]   root_o
);

  logic [N+1:0]   rem_d    [N];
  logic [N+1:0]   rem_q    [N];
  logic [N-1:0]   root_d   [N];
  logic [N-1:0]   root_q   [N];
  logic [2*N-1:0] rad_d    [N];
  logic [2*N-1:0] rad_q    [N];
  logic [N+1:0]   src_rem  [N];
  logic [N-1:0]   src_root [N];
  logic [2*N-1:0] src_rad  [N];
  logic [N+1:0]   part     [N];
  logic [N+1:0]   trial    [N];
  logic           ge       [N];

  // digit by digit root, two radicand bits per stage
  always_comb begin
    for (int k = 0; k < N; k++) begin
      if (k == 0) begin
        src_rem[k]  = '0;
        src_root[k] = '0;
        src_rad[k]  = rad_i;
      end else begin
        src_rem[k]  = rem_q[k-1];
        src_root[k] = root_q[k-1];
        src_rad[k]  = rad_q[k-1];
      end
      part[k]   = {src_rem[k][N-1:0], src_rad[k][2*N-1:2*N-2]};
      trial[k]  = {src_root[k], 2'b01};
      ge[k]     = part[k] >= trial[k];
      rem_d[k]  = ge[k] ? part[k] - trial[k] : part[k];
      root_d[k] = {src_root[k][N-2:0], ge[k]};
      rad_d[k]  = {src_rad[k][2*N-3:0], 2'b00};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q  <= rem_d;
      root_q <= root_d;
      rad_q  <= rad_d;
    end
  end

  assign root_o = root_q[N-1];

endmodule

>>> src/rci_delay.sv
module rci_delay #(
  parameter int DEPTH = 96
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  rci_pkg::side_t side_i,
  output rci_pkg::side_t side_o
);

  rci_pkg::side_t pipe_q [DEPTH];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < DEPTH; k++) begin
        pipe_q[k] <= '0;
      end
    end else if (en_i) begin
      pipe_q[0] <= side_i;
      for (int k = 1; k < DEPTH; k++) begin
        pipe_q[k] <= pipe_q[k-1];
      end
    end
  end

  assign side_o = pipe_q[DEPTH-1];

endmodule

>>> tb/tb_ray_circle_intersection.sv
module tb_ray_circle_intersection;

  localparam int Latency = 110;
  localparam int CycleLimit = 400000;

  typedef struct {
    bit        hit;
    bit        in_circ;
    bit [31:0] length;
  } ray_result_t;

  class ray_scoreboard;
    logic signed [63:0] cen_x;
    logic signed [63:0] cen_y;
    logic [127:0]       rad;
    ray_result_t        expected_q[$];
    int                 errors;

    function new();
      cen_x  = 0;
      cen_y  = 0;
      rad    = 65536;
      errors = 0;
    endfunction

    function void set_reg(rci_pkg::cfg_reg_e idx, logic [31:0] data);
      case (idx)
        rci_pkg::CFG_CENTER_X: cen_x = $signed(data);
        rci_pkg::CFG_CENTER_Y: cen_y = $signed(data);
        rci_pkg::CFG_RADIUS:   rad = data[30:0];
        default: ;
      endcase
    endfunction

    function logic [63:0] floor_sqrt(logic [63:0] n);
      logic [63:0] res;
      logic [63:0] bt;
      res = 0;
      bt  = 64'd1 << 62;
      while (bt > n) bt = bt >> 2;
      while (bt != 0) begin
        if (n >= res + bt) begin
          n   = n - (res + bt);
          res = (res >> 1) + bt;
        end else begin
          res = res >> 1;
        end
        bt = bt >> 2;
      end
      return res;
    endfunction

    function logic [63:0] div_sat(logic [127:0] n, logic [127:0] d);
      logic [127:0] q;
      q = n / d;
      return (q[127:64] != 0) ? 64'hFFFF_FFFF_FFFF_FFFF : q[63:0];
    endfunction

    function void note_ray(logic signed [31:0] ox, logic signed [31:0] oy,
                           logic signed [18:0] dx, logic signed [18:0] dy);
      logic signed [63:0] a, b, u, v, pn, xn;
      logic [127:0]       ma, mb, rr2, dist2, an, ar, c2, mpn, mxn;
      logic [63:0]        w, p, len;
      ray_result_t        e;
      a = ox;
      b = oy;
      u = dx;
      v = dy;
      a = a - cen_x;
      b = b - cen_y;
      e = '{hit: 0, in_circ: 0, length: 0};
      ma = (a < 0) ? -a : a;
      mb = (b < 0) ? -b : b;
      rr2 = rad * rad;
      dist2 = ma * ma + mb * mb;
      if (dist2 <= rr2) begin
        e.in_circ = 1;
      end else begin
        an  = u * u + v * v;
        pn  = a * u + b * v;
        xn  = a * v - b * u;
        mpn = (pn < 0) ? -pn : pn;
        mxn = (xn < 0) ? -xn : xn;
        ar  = an * rr2;
        c2  = mxn * mxn;
        if (ar > c2) begin
          w   = floor_sqrt(div_sat(ar - c2, an));
          p   = floor_sqrt(div_sat(mpn * mpn, an));
          len = (pn < 0) ? p - w : p + w;
          e.hit    = 1;
          e.length = (len > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : len[31:0];
        end
      end
      expected_q.push_back(e);
    endfunction

    function void check_result(bit hit, bit in_err, bit [31:0] length);
      ray_result_t e;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result hit=%0d err=%0d len=%h", hit, in_err, length);
        return;
      end
      e = expected_q.pop_front();
      if (e.hit !== hit || e.in_circ !== in_err || e.length !== length) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: exp hit=%0d err=%0d len=%h, got hit=%0d err=%0d len=%h",
                   e.hit, e.in_circ, e.length, hit, in_err, length);
      end
    endfunction
  endclass

  logic              clk_i = 0;
  logic              rst_ni;
  logic              in_valid;
  logic              in_ready;
  logic signed [31:0] origin_x;
  logic signed [31:0] origin_y;
  logic signed [18:0] dir_x;
  logic signed [18:0] dir_y;
  logic              out_valid;
  logic              out_ready;
  logic              hit;
  logic              inside_error;
  logic [31:0]       hit_length;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [1:0]        cfg_index;
  logic [31:0]       cfg_data;

  ray_scoreboard sb = new();
  bit  quiet;
  int  cycles;
  int  stall_left;

  always #5 clk_i = ~clk_i;

  ray_circle_intersection i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .origin_x_i     (origin_x),
    .origin_y_i     (origin_y),
    .dir_x_i        (dir_x),
    .dir_y_i        (dir_y),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .hit_o          (hit),
    .inside_error_o (inside_error),
    .hit_length_o   (hit_length),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("tb_ray_circle_intersection NOT OK");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid && out_ready) sb.check_result(hit, inside_error, hit_length);
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= (stall_left == 1);
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(1, 5);
      out_ready  <= 0;
    end else begin
      out_ready <= 1;
    end
  end

  task automatic send_ray(input logic [31:0] ox, input logic [31:0] oy,
                          input logic [18:0] dx, input logic [18:0] dy);
    in_valid <= 1;
    origin_x <= ox;
    origin_y <= oy;
    dir_x    <= dx;
    dir_y    <= dy;
    do @(posedge clk_i); while (!in_ready);
    sb.note_ray(ox, oy, dx, dy);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
  endtask

  task automatic write_reg(input rci_pkg::cfg_reg_e idx, input logic [31:0] data);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk_i); while (!cfg_ready);
    sb.set_reg(idx, data);
    cfg_valid <= 0;
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (Latency) @(posedge clk_i);
  endtask

  task automatic random_ray();
    logic [31:0] ox, oy, off_x, off_y;
    logic [18:0] dx, dy;
    int          rbits;
    if ($urandom_range(0, 6) == 0) begin
      ox = $urandom;
      oy = $urandom;
      dx = 19'($urandom);
      dy = 19'($urandom);
    end else begin
      rbits = $clog2(sb.rad + 2) + 3;
      if (rbits > 31) rbits = 31;
      off_x = $urandom & ((32'd1 << $urandom_range(1, rbits)) - 1);
      off_y = $urandom & ((32'd1 << $urandom_range(1, rbits)) - 1);
      if ($urandom_range(0, 1)) off_x = -off_x;
      if ($urandom_range(0, 1)) off_y = -off_y;
      ox = sb.cen_x[31:0] + off_x;
      oy = sb.cen_y[31:0] + off_y;
      dx = 19'($signed($urandom_range(0, 262144)) - 131072);
      dy = 19'($signed($urandom_range(0, 262144)) - 131072);
      case ($urandom_range(0, 7))
        0: dx = 0;
        1: dy = 0;
        2: begin
          dx = 19'(-(off_x >>> 13));
          dy = 19'(-(off_y >>> 13));
        end
        default: ;
      endcase
    end
    send_ray(ox, oy, dx, dy);
  endtask

  initial begin
    logic [31:0] settings [5][3];
    rst_ni    <= 0;
    in_valid  <= 0;
    origin_x  <= 0;
    origin_y  <= 0;
    dir_x     <= 0;
    dir_y     <= 0;
    cfg_valid <= 0;
    cfg_index <= rci_pkg::CFG_CENTER_X;
    cfg_data  <= 0;
    quiet      = 0;
    settings[0] = '{32'h7FFF_FFFF, 32'h0, 32'd65536};
    settings[1] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF};
    settings[2] = '{$urandom, $urandom, 32'h0};
    settings[3] = '{32'd1234567, -32'sd98765, 32'd300000};
    settings[4] = '{32'h0, 32'h0, 32'd65536};
    repeat (12) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // reset configuration: unit circle at the origin
    send_ray(-32'sd131072, 0, 19'sd65536, 0);
    send_ray(-32'sd131072, 0, -19'sd65536, 0);
    send_ray(0, 0, 19'sd65536, 0);
    send_ray(32'sd65536, 0, 0, 19'sd65536);
    send_ray(32'sd131072, 32'sd131072, 0, 0);
    send_ray(32'sd32768, -32'sd196608, 0, 19'sd65536);
    send_ray(32'sd65536, -32'sd196608, 0, 19'sd65536);
    send_ray(32'sd65536, -32'sd196608, 0, -19'sd131072);
    send_ray(-32'sd196608, 32'sd65535, 19'sd131072, 0);
    send_ray(32'h8000_0000, 32'h0, 19'sd131072, 0);
    send_ray(32'h7FFF_FFFF, 32'h7FFF_FFFF, -19'sd131072, -19'sd131072);
    send_ray(32'h8000_0000, 32'h8000_0000, 19'h3FFFF, 19'h3FFFF);
    send_ray(32'h7FFF_FFFF, 32'h0, 19'h40000, 19'h40000);
    send_ray(-32'sd200000, 32'sd3000, 19'sd1, 19'sd0);
    send_ray(-32'sd200000, 32'sd3000, 19'h7FFFF, 19'h00001);
    repeat (75) random_ray();
    drain();

    for (int s = 0; s < 5; s++) begin
      write_reg(rci_pkg::CFG_CENTER_X, settings[s][0]);
      write_reg(rci_pkg::CFG_CENTER_Y, settings[s][1]);
      write_reg(rci_pkg::CFG_RADIUS, settings[s][2]);
      if (s == 4) quiet = 1;
      if (s == 0) begin
        send_ray(32'h8000_0000, 0, 19'sd65536, 0);
        send_ray(32'h8000_0000, 0, 19'sd1, 0);
      end
      if (s == 1) send_ray(32'h7FFF_FFFF, 32'h7FFF_FFFF, 19'sd1, 19'sd2);
      if (s == 2) send_ray(settings[s][0], settings[s][1], 19'sd65536, 0);
      for (int k = 0; k < 75; k++) begin
        if (s == 2 && k == 40) begin
          in_valid <= 0;
          while (sb.expected_q.size() != 0) @(posedge clk_i);
        end
        random_ray();
      end
      drain();
    end

    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("tb_ray_circle_intersection OK");
    end else begin
      $display("tb_ray_circle_intersection NOT OK");
    end
    $finish;
  end

endmodule

>>> ray_circle_intersection.f
+incdir+src
src/rci_pkg.sv
src/rci_mul.sv
src/rci_div.sv
src/rci_sqrt.sv
src/rci_delay.sv
src/ray_circle_intersection.sv
tb/tb_ray_circle_intersection.sv
